// ----- sv/assert_macros.svh -----
// assertion macros used by the sector cache datapath
// expects signals named clk and rst_n in the module that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define SCC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define SCC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/scc_pkg.sv -----
// shared types and constants for the sector cache tag and clock replacement block
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package scc_pkg;

    localparam int SLOTS       = 64;
    localparam int SECTOR_BITS = 32;
    localparam int SLOT_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W       = SLOT_W + 1;

    // request command codes
    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_FLUSH = 2'd2,
        CMD_NONE  = 2'd3
    } command_t;

    typedef struct packed {
        command_t                command;
        logic [SECTOR_BITS-1:0]  sector;
    } req_t;

    typedef struct packed {
        logic [SLOT_W-1:0]       slot;
        logic                    hit;
        logic                    fill_needed;
        logic                    writeback_valid;
        logic [SECTOR_BITS-1:0]  writeback_sector;
        logic                    last;
    } rsp_t;

    // controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_HIT,
        ST_SWEEP,
        ST_VREAD,
        ST_INSTALL,
        ST_FL_SCAN,
        ST_FL_CAP,
        ST_FL_END
    } state_t;

    // tag memory read address source
    typedef enum logic [1:0] {
        RD_NONE,
        RD_SCAN,
        RD_SEL
    } rd_sel_t;

    // kind of result loaded into the output register
    typedef enum logic [2:0] {
        EMIT_NONE,
        EMIT_HIT,
        EMIT_MISS,
        EMIT_PEND,
        EMIT_PEND_LAST
    } emit_t;

    // controller to datapath commands
    typedef struct packed {
        logic    start;
        logic    lookup_step;
        logic    sweep_step;
        logic    flush_take;
        logic    flush_skip;
        logic    pend_load;
        rd_sel_t rd_sel;
        emit_t   emit;
    } dp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic lk_match;
        logic lk_last;
        logic free_any;
        logic sweep_hit;
        logic fl_end;
        logic fl_dirty;
        logic pend_vld;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

// ----- sv/scc_ctrl.sv -----
// controller state machine for the sector cache block
// depends on scc_pkg; drives the datapath through dp_cmd_t
`timescale 1ns / 1ps
`default_nettype none

module scc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  scc_pkg::command_t    req_command,
    input  scc_pkg::dp_status_t  status,
    output scc_pkg::dp_cmd_t     cmd
);

    import scc_pkg::*;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    unique case (req_command) inside
                        CMD_READ, CMD_WRITE: state_next = ST_LOOKUP;
                        CMD_FLUSH:           state_next = ST_FL_SCAN;
                        default:             state_next = ST_IDLE;
                    endcase
                end
            end
            ST_LOOKUP:
            begin
                if (status.lk_match)
                    state_next = ST_HIT;
                else if (status.lk_last)
                    state_next = status.free_any ? ST_INSTALL : ST_SWEEP;
            end
            ST_HIT:
            begin
                if (status.out_free)
                    state_next = ST_IDLE;
            end
            ST_SWEEP:
            begin
                if (status.sweep_hit)
                    state_next = ST_VREAD;
            end
            ST_VREAD:
            begin
                state_next = ST_INSTALL;
            end
            ST_INSTALL:
            begin
                if (status.out_free)
                    state_next = ST_IDLE;
            end
            ST_FL_SCAN:
            begin
                if (status.fl_end)
                    state_next = ST_FL_END;
                else if (status.fl_dirty)
                    state_next = ST_FL_CAP;
            end
            ST_FL_CAP:
            begin
                if (!status.pend_vld || status.out_free)
                    state_next = ST_FL_SCAN;
            end
            ST_FL_END:
            begin
                if (!status.pend_vld || status.out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        req_ready       = 1'b0;
        cmd.start       = 1'b0;
        cmd.lookup_step = 1'b0;
        cmd.sweep_step  = 1'b0;
        cmd.flush_take  = 1'b0;
        cmd.flush_skip  = 1'b0;
        cmd.pend_load   = 1'b0;
        cmd.rd_sel      = RD_NONE;
        cmd.emit        = EMIT_NONE;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                cmd.start = req_valid;
            end
            ST_LOOKUP:
            begin
                cmd.lookup_step = 1'b1;
                cmd.rd_sel      = RD_SCAN;
            end
            ST_HIT:
            begin
                if (status.out_free)
                    cmd.emit = EMIT_HIT;
            end
            ST_SWEEP:
            begin
                cmd.sweep_step = 1'b1;
            end
            ST_VREAD:
            begin
                cmd.rd_sel = RD_SEL;
            end
            ST_INSTALL:
            begin
                if (status.out_free)
                    cmd.emit = EMIT_MISS;
            end
            ST_FL_SCAN:
            begin
                if (!status.fl_end)
                begin
                    if (status.fl_dirty)
                    begin
                        cmd.flush_take = 1'b1;
                        cmd.rd_sel     = RD_SCAN;
                    end
                    else
                    begin
                        cmd.flush_skip = 1'b1;
                    end
                end
            end
            ST_FL_CAP:
            begin
                if (!status.pend_vld)
                begin
                    cmd.pend_load = 1'b1;
                end
                else if (status.out_free)
                begin
                    cmd.emit      = EMIT_PEND;
                    cmd.pend_load = 1'b1;
                end
            end
            ST_FL_END:
            begin
                if (status.pend_vld && status.out_free)
                    cmd.emit = EMIT_PEND_LAST;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- sv/scc_datapath.sv -----
// datapath for the sector cache block: tag memory, policy bits, clock hand,
// scan counter, flush holding register and output register; depends on scc_pkg
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module scc_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  scc_pkg::req_t        req,
    input  scc_pkg::dp_cmd_t     cmd,
    output scc_pkg::dp_status_t  status,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output scc_pkg::rsp_t        rsp
);

    import scc_pkg::*;

    // tag memory, no reset: only read behind a valid bit
    logic [SECTOR_BITS-1:0] tag_mem [SLOTS];
    logic [SECTOR_BITS-1:0] tag_rd_reg;

    // policy bits
    logic [SLOTS-1:0] valid_reg, valid_next;
    logic [SLOTS-1:0] dirty_reg, dirty_next;
    logic [SLOTS-1:0] access_reg, access_next;
    logic [SLOT_W-1:0] hand_reg, hand_next;

    // request and scan state
    logic [SECTOR_BITS-1:0] sector_reg;
    logic                   write_reg;
    logic [CNT_W-1:0]       idx_reg;
    logic [SLOT_W-1:0]      pidx_reg;
    logic                   pvld_reg;
    logic                   free_found_reg;
    logic [SLOT_W-1:0]      sel_reg;
    logic                   wbv_reg;

    // flush holding register
    logic                   pend_vld_reg;
    logic [SLOT_W-1:0]      pend_slot_reg;
    logic [SECTOR_BITS-1:0] pend_tag_reg;

    // output register
    logic rsp_valid_reg;
    rsp_t rsp_reg, rsp_next;

    logic [SLOT_W-1:0] idx_slot;
    logic [SLOT_W-1:0] rd_addr;
    logic              idx_in_range;
    logic              lk_match;
    logic              take_free;
    logic              sweep_hit;

    assign idx_slot     = idx_reg[SLOT_W-1:0];
    assign idx_in_range = (idx_reg < CNT_W'(SLOTS));
    assign lk_match     = pvld_reg && valid_reg[pidx_reg] && (tag_rd_reg == sector_reg);
    assign take_free    = pvld_reg && !valid_reg[pidx_reg] && !free_found_reg;
    assign sweep_hit    = !access_reg[hand_reg];
    assign rd_addr      = (cmd.rd_sel == RD_SEL) ? sel_reg : idx_slot;

    // status to the controller
    always_comb
    begin
        status.lk_match  = lk_match;
        status.lk_last   = pvld_reg && (pidx_reg == SLOT_W'(SLOTS - 1));
        status.free_any  = free_found_reg || (pvld_reg && !valid_reg[pidx_reg]);
        status.sweep_hit = sweep_hit;
        status.fl_end    = !idx_in_range;
        status.fl_dirty  = idx_in_range && valid_reg[idx_slot] && dirty_reg[idx_slot];
        status.pend_vld  = pend_vld_reg;
        status.out_free  = !rsp_valid_reg || rsp_ready;
    end

    // tag memory write on install
    always_ff @(posedge clk)
    begin
        if (cmd.emit == EMIT_MISS)
            tag_mem[sel_reg] <= sector_reg;
    end

    // tag memory registered read
    always_ff @(posedge clk)
    begin
        if (cmd.rd_sel != RD_NONE)
            tag_rd_reg <= tag_mem[rd_addr];
    end

    // policy bit updates
    always_comb
    begin
        valid_next  = valid_reg;
        dirty_next  = dirty_reg;
        access_next = access_reg;
        if (cmd.sweep_step && !sweep_hit)
            access_next[hand_reg] = 1'b0;
        if (cmd.flush_take)
            dirty_next[idx_slot] = 1'b0;
        case (cmd.emit)
            EMIT_HIT:
            begin
                access_next[sel_reg] = 1'b1;
                if (write_reg)
                    dirty_next[sel_reg] = 1'b1;
            end
            EMIT_MISS:
            begin
                valid_next[sel_reg]  = 1'b1;
                access_next[sel_reg] = 1'b1;
                dirty_next[sel_reg]  = write_reg;
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    // clock hand advances on every sweep step, wrapping at the slot count
    always_comb
    begin
        hand_next = hand_reg;
        if (cmd.sweep_step)
            hand_next = (hand_reg == SLOT_W'(SLOTS - 1)) ? '0 : hand_reg + SLOT_W'(1);
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            dirty_reg      <= '0;
            access_reg     <= '0;
            hand_reg       <= '0;
            idx_reg        <= '0;
            pvld_reg       <= 1'b0;
            free_found_reg <= 1'b0;
            wbv_reg        <= 1'b0;
            pend_vld_reg   <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            valid_reg  <= valid_next;
            dirty_reg  <= dirty_next;
            access_reg <= access_next;
            hand_reg   <= hand_next;

            if (cmd.start)
            begin
                idx_reg        <= '0;
                pvld_reg       <= 1'b0;
                free_found_reg <= 1'b0;
                wbv_reg        <= 1'b0;
                pend_vld_reg   <= 1'b0;
            end
            else
            begin
                // lookup: issue read at idx, compare in the next cycle
                if (cmd.lookup_step)
                begin
                    pvld_reg <= idx_in_range;
                    if (idx_in_range)
                        idx_reg <= idx_reg + CNT_W'(1);
                    if (take_free)
                        free_found_reg <= 1'b1;
                end
                // victim found: remember whether it is dirty
                if (cmd.sweep_step && sweep_hit)
                    wbv_reg <= dirty_reg[hand_reg];
                // flush scan
                if (cmd.flush_take || cmd.flush_skip)
                    idx_reg <= idx_reg + CNT_W'(1);
                if (cmd.pend_load)
                    pend_vld_reg <= 1'b1;
                else if (cmd.emit == EMIT_PEND_LAST)
                    pend_vld_reg <= 1'b0;
            end

            // output valid
            if (cmd.emit != EMIT_NONE)
                rsp_valid_reg <= 1'b1;
            else if (rsp_ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            sector_reg <= req.sector;
            write_reg  <= (req.command == CMD_WRITE);
        end
        if (cmd.lookup_step)
            pidx_reg <= idx_slot;
        if (cmd.lookup_step && (lk_match || take_free))
            sel_reg <= pidx_reg;
        else if (cmd.sweep_step && sweep_hit)
            sel_reg <= hand_reg;
        else if (cmd.flush_take)
            sel_reg <= idx_slot;
        if (cmd.pend_load)
        begin
            pend_slot_reg <= sel_reg;
            pend_tag_reg  <= tag_rd_reg;
        end
        if (cmd.emit != EMIT_NONE)
            rsp_reg <= rsp_next;
    end

    // result formatting
    always_comb
    begin
        rsp_next.slot             = sel_reg;
        rsp_next.hit              = 1'b0;
        rsp_next.fill_needed      = 1'b0;
        rsp_next.writeback_valid  = 1'b0;
        rsp_next.writeback_sector = '0;
        rsp_next.last             = 1'b1;
        case (cmd.emit) inside
            EMIT_HIT:
            begin
                rsp_next.hit = 1'b1;
            end
            EMIT_MISS:
            begin
                rsp_next.fill_needed      = 1'b1;
                rsp_next.writeback_valid  = wbv_reg;
                rsp_next.writeback_sector = wbv_reg ? tag_rd_reg : '0;
            end
            EMIT_PEND, EMIT_PEND_LAST:
            begin
                rsp_next.slot             = pend_slot_reg;
                rsp_next.writeback_valid  = 1'b1;
                rsp_next.writeback_sector = pend_tag_reg;
                rsp_next.last             = (cmd.emit == EMIT_PEND_LAST);
            end
            default:
            begin
                rsp_next.slot = sel_reg;
            end
        endcase
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // checks
    `SCC_ASSERT_IMP(a_emit_free, cmd.emit != EMIT_NONE, !rsp_valid_reg || rsp_ready,
                    "result loaded over an unread result")
    `SCC_ASSERT_NXT(a_miss_marks, cmd.emit == EMIT_MISS,
                    valid_reg[$past(sel_reg)] && access_reg[$past(sel_reg)],
                    "installed slot not valid and referenced")
    `SCC_ASSERT_IMP(a_take_dirty, cmd.flush_take,
                    idx_in_range && valid_reg[idx_slot] && dirty_reg[idx_slot],
                    "flush took a clean slot")
    `SCC_ASSERT_IMP(a_hit_clean, rsp_valid_reg && rsp_reg.hit,
                    !rsp_reg.writeback_valid && !rsp_reg.fill_needed && rsp_reg.last,
                    "hit result with miss fields")

endmodule

`default_nettype wire

// ----- sv/sector_cache_clock_replacement_top.sv -----
// top level of the sector cache tag and clock replacement block
// depends on scc_pkg, scc_ctrl and scc_datapath
//
// usage:
//   req channel (req_valid/req_ready/req) takes one request: read, write or flush.
//   rsp channel (rsp_valid/rsp_ready/rsp) returns results; last marks the final
//   result of a request. unused command code gives no result.
// sequencing:
//   one request at a time; req_ready is high only while the controller is idle.
//   read/write: the tag search reads one slot per cycle from the tag memory
//   (one read port); the search stops at a hit, while a miss scans every slot;
//   a miss with no free slot adds the clock sweep (one slot per cycle) and a tag
//   read of the victim. flush: scans every slot and returns one result for each
//   dirty slot found.
// reset: rst_n clears all valid, dirty and access bits and the hand; the tag
//   memory is not cleared and no clearing pass is needed.
// stall: results sit in an output register until taken; the controller waits
//   while it is full, and a new request may be taken while a result waits.
`timescale 1ns / 1ps
`default_nettype none

module sector_cache_clock_replacement_top (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  scc_pkg::req_t  req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output scc_pkg::rsp_t  rsp
);

    import scc_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // controller
    scc_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req_command (req.command),
        .status      (status),
        .cmd         (cmd)
    );

    // datapath
    scc_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .status    (status),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire
